/* hw/rtl/wsv_pkg.sv */
// Package for the waveguide string voice: sample and coefficient widths,
// register indexes, reset values, sequencer states and shared structs.
// No dependencies; compile first.
package wsv_pkg;

	localparam int SAMPLE_W        = 16;
	localparam int COEF_W          = 18;
	localparam int GAIN_W          = 16;
	localparam int PERIOD_W        = 12;
	localparam int CFG_IDX_W       = 4;
	localparam int CFG_DATA_W      = 18;
	localparam int DELAY_DEPTH_DEF = 4096;

	// product of an 18-bit coefficient and a 16-bit sample
	localparam int PROD_W = COEF_W + SAMPLE_W;
	// five products summed, with headroom
	localparam int ACC_W  = PROD_W + 4;

	localparam logic [PERIOD_W-1:0]      PERIOD_RST    = 12'd100;
	localparam logic signed [COEF_W-1:0] FF_COEF0_RST  = 18'sd64881;
	localparam logic signed [COEF_W-1:0] FF_COEF1_RST  = 18'sd655;
	localparam logic signed [COEF_W-1:0] FF_COEF2_RST  = 18'sd0;
	localparam logic signed [COEF_W-1:0] FB_COEF1_RST  = 18'sd0;
	localparam logic signed [COEF_W-1:0] FB_COEF2_RST  = 18'sd0;
	localparam logic [GAIN_W-1:0]        DC_POLE_RST   = 16'd65530;
	localparam logic [GAIN_W-1:0]        DECAY_RST     = 16'd65208;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DELAY_PERIOD = 4'd0,
		REG_FF_COEF0     = 4'd1,
		REG_FF_COEF1     = 4'd2,
		REG_FF_COEF2     = 4'd3,
		REG_FB_COEF1     = 4'd4,
		REG_FB_COEF2     = 4'd5,
		REG_DC_POLE_GAIN = 4'd6,
		REG_DECAY_GAIN   = 4'd7
	} wsv_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL0,
		ST_MUL1,
		ST_MUL2,
		ST_MUL3,
		ST_MUL4,
		ST_ACC,
		ST_DAMP,
		ST_DC,
		ST_HPF,
		ST_DECAY,
		ST_OUT
	} wsv_state_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] ff_coef0;
		logic signed [COEF_W-1:0] ff_coef1;
		logic signed [COEF_W-1:0] ff_coef2;
		logic signed [COEF_W-1:0] fb_coef1;
		logic signed [COEF_W-1:0] fb_coef2;
		logic [GAIN_W-1:0]        dc_pole_gain;
		logic [GAIN_W-1:0]        decay_gain;
	} wsv_coef_t;

	typedef struct packed {
		logic start;
		logic out_free;
	} wsv_eng_ctrl_t;

	typedef struct packed {
		logic idle;
		logic done;
	} wsv_eng_stat_t;

endpackage

/* hw/rtl/wsv_in_if.sv */
// Input sample channel: valid/ready with one signed audio sample.
// Depends on wsv_pkg.
interface wsv_in_if import wsv_pkg::*; ;
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink   (input valid, input sample_in, output ready);
endinterface

/* hw/rtl/wsv_out_if.sv */
// Output sample channel: valid/ready with one processed audio sample.
// Depends on wsv_pkg.
interface wsv_out_if import wsv_pkg::*; ;
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink   (input valid, input sample_out, output ready);
endinterface

/* hw/rtl/wsv_cfg_if.sv */
// Configuration write channel: valid/ready with register index and data.
// Depends on wsv_pkg.
interface wsv_cfg_if import wsv_pkg::*; ;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/wsv_cfg_regs.sv */
// Configuration register file; reduces the delay period modulo the depth
// when it is written. Depends on wsv_pkg and wsv_cfg_if.
module wsv_cfg_regs import wsv_pkg::*; #(
	parameter int DELAY_DEPTH = DELAY_DEPTH_DEF,
	parameter int AW          = $clog2(DELAY_DEPTH)
) (
	input  logic          clk,
	input  logic          arst_n,
	wsv_cfg_if.sink       cfg,
	output wsv_coef_t     coef,
	output logic [AW-1:0] period
);

	// conditional-subtract chain against shifted copies of the depth
	function automatic logic [PERIOD_W-1:0] period_reduce(input logic [PERIOD_W-1:0] v);
		logic [31:0] rem;
		logic [47:0] step;
		rem = 32'(v);
		for (int k = PERIOD_W - 1; k >= 0; k--) begin
			step = 48'(DELAY_DEPTH) << k;
			if (step <= 48'(rem)) begin
				rem = rem - 32'(step);
			end
		end
		return rem[PERIOD_W-1:0];
	endfunction

	wsv_coef_t     coef_q;
	logic [AW-1:0] period_q;
	logic          wr;

	assign cfg.ready = 1'b1;
	assign wr        = cfg.valid & cfg.ready;
	assign coef      = coef_q;
	assign period    = period_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q            <= AW'(period_reduce(PERIOD_RST));
			coef_q.ff_coef0     <= FF_COEF0_RST;
			coef_q.ff_coef1     <= FF_COEF1_RST;
			coef_q.ff_coef2     <= FF_COEF2_RST;
			coef_q.fb_coef1     <= FB_COEF1_RST;
			coef_q.fb_coef2     <= FB_COEF2_RST;
			coef_q.dc_pole_gain <= DC_POLE_RST;
			coef_q.decay_gain   <= DECAY_RST;
		end else if (wr) begin
			unique case (cfg.index)
				REG_DELAY_PERIOD: period_q <= AW'(period_reduce(cfg.data[PERIOD_W-1:0]));
				REG_FF_COEF0:     coef_q.ff_coef0 <= $signed(cfg.data[COEF_W-1:0]);
				REG_FF_COEF1:     coef_q.ff_coef1 <= $signed(cfg.data[COEF_W-1:0]);
				REG_FF_COEF2:     coef_q.ff_coef2 <= $signed(cfg.data[COEF_W-1:0]);
				REG_FB_COEF1:     coef_q.fb_coef1 <= $signed(cfg.data[COEF_W-1:0]);
				REG_FB_COEF2:     coef_q.fb_coef2 <= $signed(cfg.data[COEF_W-1:0]);
				REG_DC_POLE_GAIN: coef_q.dc_pole_gain <= cfg.data[GAIN_W-1:0];
				REG_DECAY_GAIN:   coef_q.decay_gain <= cfg.data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

/* hw/rtl/wsv_delay_line.sv */
// Circular delay store: one write and one registered read per sample,
// with a fill check for never-written entries. Depends on wsv_pkg.
module wsv_delay_line import wsv_pkg::*; #(
	parameter int DELAY_DEPTH = DELAY_DEPTH_DEF,
	parameter int AW          = $clog2(DELAY_DEPTH)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic [AW-1:0]              period,
	output logic signed [SAMPLE_W-1:0] delayed
);

	logic [SAMPLE_W-1:0] mem [DELAY_DEPTH];
	logic [SAMPLE_W-1:0] rdata_q;
	logic [SAMPLE_W-1:0] fwd_data_q;
	logic [AW-1:0]       widx_q;
	logic                wrapped_q;
	logic                fwd_q;
	logic                hit_q;

	logic [AW-1:0]       widx_nxt;
	logic [AW:0]         rd_sum;
	logic [AW-1:0]       ridx;
	logic                wrapped_eff;
	logic                hit;

	assign widx_nxt = (widx_q == AW'(DELAY_DEPTH - 1)) ? '0 : widx_q + 1'b1;

	// read behind the write pointer by the period, wrapping at the depth
	always_comb begin
		if (widx_nxt >= period) begin
			rd_sum = {1'b0, widx_nxt} - {1'b0, period};
		end else begin
			rd_sum = {1'b0, widx_nxt} + (AW+1)'(DELAY_DEPTH) - {1'b0, period};
		end
	end
	assign ridx = rd_sum[AW-1:0];

	// entries 1..write index are filled until the pointer has wrapped once
	assign wrapped_eff = wrapped_q | (widx_nxt == '0);
	assign hit         = wrapped_eff | ((ridx != '0) & (ridx <= widx_nxt));

	always_ff @(posedge clk) begin
		if (push) begin
			mem[widx_nxt] <= sample;
		end
		rdata_q <= mem[ridx];
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fwd_data_q <= sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			widx_q    <= '0;
			wrapped_q <= 1'b0;
			fwd_q     <= 1'b0;
			hit_q     <= 1'b0;
		end else if (push) begin
			widx_q    <= widx_nxt;
			wrapped_q <= wrapped_eff;
			fwd_q     <= (ridx == widx_nxt);
			hit_q     <= hit;
		end
	end

	assign delayed = fwd_q ? $signed(fwd_data_q) :
	                 hit_q ? $signed(rdata_q) : '0;

endmodule

/* hw/rtl/wsv_engine.sv */
// Filter sequencer: one shared multiplier steps through the damping filter,
// DC blocker and decay gain. Depends on wsv_pkg.
module wsv_engine import wsv_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  wsv_eng_ctrl_t              ctrl,
	input  wsv_coef_t                  coef,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic signed [SAMPLE_W-1:0] delayed,
	output wsv_eng_stat_t              stat,
	output logic signed [SAMPLE_W-1:0] result
);

	// add half an LSB, floor from Q.16, clamp to 16 bits
	function automatic logic signed [SAMPLE_W-1:0] round_sat(input logic signed [ACC_W-1:0] a);
		logic signed [ACC_W:0]    v;
		logic signed [ACC_W-16:0] r;
		v = (ACC_W+1)'(a) + (ACC_W+1)'(32768);
		r = v[ACC_W:16];
		if (r > (ACC_W-15)'(32767)) begin
			return 16'sh7FFF;
		end else if (r < -(ACC_W-15)'(32768)) begin
			return 16'sh8000;
		end
		return r[SAMPLE_W-1:0];
	endfunction

	wsv_state_t state_q, state_d;

	logic signed [COEF_W-1:0]   mul_a;
	logic signed [SAMPLE_W-1:0] mul_b;
	logic signed [PROD_W-1:0]   prod_s1;
	logic signed [ACC_W-1:0]    acc_q;
	logic signed [SAMPLE_W-1:0] x_q, f_q, h_q;
	logic signed [SAMPLE_W-1:0] x1_q, x2_q, y1_q, y2_q, dc_in_q, dc_out_q;
	logic signed [SAMPLE_W:0]   dc_diff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		mul_a     = '0;
		mul_b     = '0;
		stat.idle = 1'b0;
		stat.done = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				stat.idle = 1'b1;
				if (ctrl.start) begin
					state_d = ST_MUL0;
				end
			end
			ST_MUL0: begin
				mul_a   = coef.ff_coef0;
				mul_b   = delayed;
				state_d = ST_MUL1;
			end
			ST_MUL1: begin
				mul_a   = coef.ff_coef1;
				mul_b   = x1_q;
				state_d = ST_MUL2;
			end
			ST_MUL2: begin
				mul_a   = coef.ff_coef2;
				mul_b   = x2_q;
				state_d = ST_MUL3;
			end
			ST_MUL3: begin
				mul_a   = coef.fb_coef1;
				mul_b   = y1_q;
				state_d = ST_MUL4;
			end
			ST_MUL4: begin
				mul_a   = coef.fb_coef2;
				mul_b   = y2_q;
				state_d = ST_ACC;
			end
			ST_ACC:  state_d = ST_DAMP;
			ST_DAMP: begin
				mul_a   = $signed({2'b00, coef.dc_pole_gain});
				mul_b   = dc_out_q;
				state_d = ST_DC;
			end
			ST_DC:   state_d = ST_HPF;
			ST_HPF:  state_d = ST_DECAY;
			ST_DECAY: begin
				mul_a   = $signed({2'b00, coef.decay_gain});
				mul_b   = h_q;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				// hold the decay product on the multiplier while the result waits
				mul_a = $signed({2'b00, coef.decay_gain});
				mul_b = h_q;
				if (ctrl.out_free) begin
					stat.done = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign dc_diff = (SAMPLE_W+1)'(f_q) - (SAMPLE_W+1)'(dc_in_q);
	assign result  = round_sat(ACC_W'(prod_s1));

	// the product register feeds the accumulator in the state after its operands
	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(mul_a) * PROD_W'(mul_b);
		case (state_q)
			ST_IDLE:  if (ctrl.start) x_q <= sample;
			ST_MUL1:  acc_q <= ACC_W'(prod_s1);
			ST_MUL2:  acc_q <= acc_q + ACC_W'(prod_s1);
			ST_MUL3:  acc_q <= acc_q + ACC_W'(prod_s1);
			ST_MUL4:  acc_q <= acc_q - ACC_W'(prod_s1);
			ST_ACC:   acc_q <= acc_q - ACC_W'(prod_s1);
			ST_DAMP:  f_q <= round_sat(acc_q);
			ST_DC:    acc_q <= (ACC_W'(dc_diff) <<< 16) + ACC_W'(prod_s1);
			ST_HPF:   h_q <= round_sat(acc_q);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x1_q     <= '0;
			x2_q     <= '0;
			y1_q     <= '0;
			y2_q     <= '0;
			dc_in_q  <= '0;
			dc_out_q <= '0;
		end else if (stat.done) begin
			x1_q     <= x_q;
			x2_q     <= x1_q;
			y1_q     <= result;
			y2_q     <= y1_q;
			dc_in_q  <= f_q;
			dc_out_q <= h_q;
		end
	end

endmodule

/* hw/rtl/waveguide_string_voice_core.sv */
// One voice of a plucked-string waveguide: each accepted sample is written into a circular
// delay store and the sample one period earlier is read back, then passed through a
// second-order damping filter, a DC-blocking high-pass and a decay gain, all saturating to
// 16 bits. A sample is accepted while the sequencer is idle (the delay store is written and read
// in that cycle), then the sequencer takes eleven steps around the single shared
// 18x16 multiplier, which forms the seven products one after another. The result sits in an
// output register, so the next sample is taken while it waits; the sequencer holds at its
// last step only if the previous result has still not been taken. The delay store needs no
// clearing pass after reset: a write pointer and a wrapped flag mark which entries hold data,
// and unwritten entries read as zero. Configuration writes are taken on any cycle and must
// fall while the block is idle.
module waveguide_string_voice_core import wsv_pkg::*; #(
	parameter int DELAY_DEPTH = DELAY_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	wsv_in_if.sink    feed,
	wsv_out_if.source result,
	wsv_cfg_if.sink   cfg
);

	localparam int AW = $clog2(DELAY_DEPTH);

	wsv_coef_t                  coef;
	logic [AW-1:0]              period;
	logic signed [SAMPLE_W-1:0] delayed;
	logic signed [SAMPLE_W-1:0] eng_y;
	wsv_eng_ctrl_t              eng_ctrl;
	wsv_eng_stat_t              eng_stat;

	logic                       accept;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] out_sample_q;

	// register file; period arrives already reduced modulo the depth
	wsv_cfg_regs #(
		.DELAY_DEPTH (DELAY_DEPTH),
		.AW          (AW)
	) u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.coef   (coef),
		.period (period)
	);

	// take a sample only while the sequencer is idle
	assign feed.ready = eng_stat.idle;
	assign accept     = feed.valid & feed.ready;

	// write the sample and fetch the delayed one on the accepting edge
	wsv_delay_line #(
		.DELAY_DEPTH (DELAY_DEPTH),
		.AW          (AW)
	) u_delay (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (accept),
		.sample  (feed.sample_in),
		.period  (period),
		.delayed (delayed)
	);

	// the output slot is free when empty or being emptied this cycle
	assign eng_ctrl.start    = accept;
	assign eng_ctrl.out_free = ~out_valid_q | result.ready;

	wsv_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (eng_ctrl),
		.coef    (coef),
		.sample  (feed.sample_in),
		.delayed (delayed),
		.stat    (eng_stat),
		.result  (eng_y)
	);

	// output register: load on completion, drop once the transaction is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (eng_stat.done) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (eng_stat.done) begin
			out_sample_q <= eng_y;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.sample_out = out_sample_q;

`ifndef SYNTHESIS
	// a finished sample never overwrites a result that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		eng_stat.done |-> (!out_valid_q || result.ready))
		else $error("result register overwritten while still pending");

	// an accepted sample moves the sequencer out of idle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !feed.ready)
		else $error("input still ready in the cycle after an accepted sample");

	// completion only comes from a busy sequencer
	a_done_not_idle: assert property (@(posedge clk) disable iff (!arst_n)
		eng_stat.done |-> !eng_stat.idle)
		else $error("completion flagged while sequencer idle");

	// the reduced period always addresses inside the store
	a_period_range: assert property (@(posedge clk) disable iff (!arst_n)
		(AW+1)'(period) < (AW+1)'(DELAY_DEPTH))
		else $error("delay period not reduced below the store depth");
`endif

endmodule
